// ----- design/ble_advertising_event_sequencer_core_defines.svh -----
// Assertion macros for the advertising event sequencer core.
// Expects signals named clk and arst_n in the scope of each use.
`ifndef BLE_ADVERTISING_EVENT_SEQUENCER_CORE_DEFINES_SVH
`define BLE_ADVERTISING_EVENT_SEQUENCER_CORE_DEFINES_SVH

`ifndef ASSERT_OFF

`define BLE_AES_ASSERT(label, prop) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("ble_aes assertion failed");

`define BLE_AES_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("ble_aes sequencing assertion failed");

`else

`define BLE_AES_ASSERT(label, prop)
`define BLE_AES_ASSERT_NEXT(label, ante, cons)

`endif

`endif

// ----- design/ble_aes_pkg.sv -----
// Shared types and constants of the advertising event sequencer core.
// No dependencies; used by every module of the block.
`default_nettype none

package ble_aes_pkg;

	localparam int unsigned APB_ADDR_W = 6;
	localparam int unsigned APB_DATA_W = 64;
	localparam int unsigned REG_IDX_W  = 3;

	localparam logic [REG_IDX_W-1:0] REG_LOCAL_ADDRESS        = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_LOCAL_ADDRESS_RANDOM = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_CONNECTABLE          = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_SCAN_RSP_ENABLED     = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_PHY_MODE             = 3'd4;

	localparam logic [1:0] MODE_EVENT_OPEN = 2'd0;
	localparam logic [1:0] MODE_IFS        = 2'd1;
	localparam logic [1:0] MODE_RX_PACKET  = 2'd2;

	localparam logic [1:0] ACT_SEND_ADV  = 2'd0;
	localparam logic [1:0] ACT_RX_REQ    = 2'd1;
	localparam logic [1:0] ACT_SCAN_RSP  = 2'd2;
	localparam logic [1:0] ACT_NONE      = 2'd3;

	localparam logic [3:0] PDU_SCAN_REQ = 4'd3;
	localparam logic [3:0] PDU_CONN_REQ = 4'd5;

	localparam logic [5:0] CHAN_FIRST = 6'd37;
	localparam logic [5:0] CHAN_LAST  = 6'd39;

	localparam logic [8:0] HDR_SIZE      = 9'd2;
	localparam logic [8:0] SCAN_REQ_SIZE = 9'd14;
	localparam logic [8:0] CONN_REQ_SIZE = 9'(2 + 12 + 22);

	typedef struct packed {
		logic [1:0]  mode;
		logic        timed_out;
		logic        crc_ok;
		logic [3:0]  pdu_type;
		logic [7:0]  payload_length;
		logic [47:0] target_address;
		logic        target_address_random;
		logic [31:0] timestamp;
	} item_t;

	typedef struct packed {
		logic [5:0]  channel;
		logic [1:0]  radio_action;
		logic [1:0]  radio_phy;
		logic        connect_found;
		logic [31:0] connect_time;
	} result_t;

	typedef struct packed {
		logic [47:0] local_address;
		logic        local_address_random;
		logic        connectable;
		logic        scan_response_enabled;
		logic [1:0]  phy_mode;
	} cfg_t;

endpackage

`default_nettype wire

// ----- design/ble_advertising_event_sequencer_core.sv -----
// Top level of the advertising event sequencer: input register, flow step, result register.
// Depends on ble_aes_pkg, ble_aes_cfg, ble_aes_flow and the assertion macro header.
//
//   channel   direction  handshake                      beat
//   item      in         item_valid / item_stall        ble_aes_pkg::item_t
//   result    out        result_valid / result_stall    ble_aes_pkg::result_t
//   apb       in/out     psel, penable, pwrite, pready  64-bit registers at 8*i
//
// One beat per cycle sustained while result is not stalled; every item beat gives exactly one result beat.
// An item passes the input register, then the flow step into the result register.
// The flow state updates in the same edge that loads the result register.
// A stall on a valid result holds the result register, and holds a full input register and raises item_stall.
// Reset leaves the flow done on channel 37 with no pending connection; no clearing pass.
`default_nettype none
`include "ble_advertising_event_sequencer_core_defines.svh"

module ble_advertising_event_sequencer_core (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                item_valid,
	output logic                                     item_stall,
	input  wire ble_aes_pkg::item_t                  item,
	output logic                                     result_valid,
	input  wire logic                                result_stall,
	output ble_aes_pkg::result_t                     result,
	input  wire logic                                psel,
	input  wire logic                                penable,
	input  wire logic                                pwrite,
	input  wire logic [ble_aes_pkg::APB_ADDR_W-1:0]  paddr,
	input  wire logic [ble_aes_pkg::APB_DATA_W-1:0]  pwdata,
	output logic      [ble_aes_pkg::APB_DATA_W-1:0]  prdata,
	output logic                                     pready
);

	ble_aes_pkg::cfg_t    cfg;
	ble_aes_pkg::item_t   item_s1;
	logic                 item_valid_s1;
	ble_aes_pkg::result_t step_result;
	ble_aes_pkg::result_t result_q;
	logic                 result_valid_q;
	logic                 res_load;
	logic                 item_take;

	assign pready       = 1'b1;
	assign res_load     = item_valid_s1 & (~result_valid_q | ~result_stall);
	assign item_stall   = item_valid_s1 & ~res_load;
	assign item_take    = item_valid & ~item_stall;
	assign result_valid = result_valid_q;
	assign result       = result_q;

	ble_aes_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.cfg     (cfg)
	);

	ble_aes_flow u_flow (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (res_load),
		.item   (item_s1),
		.cfg    (cfg),
		.result (step_result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			item_valid_s1  <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			if (item_take) begin
				item_valid_s1 <= 1'b1;
			end else if (res_load) begin
				item_valid_s1 <= 1'b0;
			end
			if (res_load) begin
				result_valid_q <= 1'b1;
			end else if (~result_stall) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (item_take) begin
			item_s1 <= item;
		end
		if (res_load) begin
			result_q <= step_result;
		end
	end

	`BLE_AES_ASSERT(a_chan_range, !result_valid_q || (result_q.channel >= ble_aes_pkg::CHAN_FIRST && result_q.channel <= ble_aes_pkg::CHAN_LAST))
	`BLE_AES_ASSERT(a_conn_quiet, !result_valid_q || !result_q.connect_found || result_q.radio_action == ble_aes_pkg::ACT_NONE)
	`BLE_AES_ASSERT(a_conn_time, !result_valid_q || result_q.connect_found || result_q.connect_time == 32'd0)
	`BLE_AES_ASSERT_NEXT(a_s1_drains, item_valid_s1 && !(result_valid_q && result_stall), result_valid_q)

endmodule

`default_nettype wire

// ----- design/ble_aes_cfg.sv -----
// Configuration register file behind the APB port.
// Depends on ble_aes_pkg for the register map and the cfg_t bundle.
`default_nettype none

module ble_aes_cfg (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                psel,
	input  wire logic                                penable,
	input  wire logic                                pwrite,
	input  wire logic [ble_aes_pkg::APB_ADDR_W-1:0]  paddr,
	input  wire logic [ble_aes_pkg::APB_DATA_W-1:0]  pwdata,
	output logic      [ble_aes_pkg::APB_DATA_W-1:0]  prdata,
	output ble_aes_pkg::cfg_t                        cfg
);

	logic [ble_aes_pkg::REG_IDX_W-1:0] idx;
	logic                              wr_en;
	ble_aes_pkg::cfg_t                 cfg_q;

	assign idx   = paddr[ble_aes_pkg::APB_ADDR_W-1:3];
	assign wr_en = psel & penable & pwrite;
	assign cfg   = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.local_address         <= '0;
			cfg_q.local_address_random  <= 1'b0;
			cfg_q.connectable           <= 1'b0;
			cfg_q.scan_response_enabled <= 1'b1;
			cfg_q.phy_mode              <= 2'd0;
		end else if (wr_en) begin
			case (idx)
				ble_aes_pkg::REG_LOCAL_ADDRESS: begin
					cfg_q.local_address <= pwdata[47:0];
				end
				ble_aes_pkg::REG_LOCAL_ADDRESS_RANDOM: begin
					cfg_q.local_address_random <= pwdata[0];
				end
				ble_aes_pkg::REG_CONNECTABLE: begin
					cfg_q.connectable <= pwdata[0];
				end
				ble_aes_pkg::REG_SCAN_RSP_ENABLED: begin
					cfg_q.scan_response_enabled <= pwdata[0];
				end
				ble_aes_pkg::REG_PHY_MODE: begin
					cfg_q.phy_mode <= pwdata[1:0];
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (idx)
			ble_aes_pkg::REG_LOCAL_ADDRESS: begin
				prdata = {16'd0, cfg_q.local_address};
			end
			ble_aes_pkg::REG_LOCAL_ADDRESS_RANDOM: begin
				prdata = {63'd0, cfg_q.local_address_random};
			end
			ble_aes_pkg::REG_CONNECTABLE: begin
				prdata = {63'd0, cfg_q.connectable};
			end
			ble_aes_pkg::REG_SCAN_RSP_ENABLED: begin
				prdata = {63'd0, cfg_q.scan_response_enabled};
			end
			ble_aes_pkg::REG_PHY_MODE: begin
				prdata = {62'd0, cfg_q.phy_mode};
			end
			default: begin
				prdata = '0;
			end
		endcase
	end

endmodule

`default_nettype wire

// ----- design/ble_aes_flow.sv -----
// Event flow state, packet checks and next radio action for one beat.
// Depends on ble_aes_pkg for the beat types and protocol constants.
`default_nettype none

module ble_aes_flow (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 step,
	input  wire ble_aes_pkg::item_t   item,
	input  wire ble_aes_pkg::cfg_t    cfg,
	output ble_aes_pkg::result_t      result
);

	typedef enum logic [1:0] {
		FS_ADV,
		FS_LISTEN,
		FS_RSP,
		FS_DONE
	} flow_t;

	flow_t       flow_q, flow_d;
	logic [5:0]  chan_q, chan_d;
	logic        pend_q, pend_d;
	logic [31:0] stamp_q, stamp_d;

	flow_t       adv_flow;
	logic [5:0]  adv_chan;
	logic [8:0]  rx_size;
	logic        addr_ok;
	logic        scan_ok;
	logic        conn_ok;

	assign adv_chan = (chan_q < ble_aes_pkg::CHAN_LAST) ? chan_q + 6'd1 : chan_q;
	assign adv_flow = (chan_q < ble_aes_pkg::CHAN_LAST) ? FS_ADV : FS_DONE;

	assign rx_size = {1'b0, item.payload_length} + ble_aes_pkg::HDR_SIZE;
	assign addr_ok = (item.target_address == cfg.local_address) &&
		(item.target_address_random == cfg.local_address_random);
	assign scan_ok = item.crc_ok && (item.pdu_type == ble_aes_pkg::PDU_SCAN_REQ) &&
		(rx_size == ble_aes_pkg::SCAN_REQ_SIZE) && addr_ok && cfg.scan_response_enabled;
	assign conn_ok = item.crc_ok && (item.pdu_type == ble_aes_pkg::PDU_CONN_REQ) &&
		(rx_size == ble_aes_pkg::CONN_REQ_SIZE) && addr_ok && cfg.connectable;

	always_comb begin
		flow_d  = flow_q;
		chan_d  = chan_q;
		pend_d  = pend_q;
		stamp_d = stamp_q;
		case (item.mode)
			ble_aes_pkg::MODE_EVENT_OPEN: begin
				flow_d  = FS_ADV;
				chan_d  = ble_aes_pkg::CHAN_FIRST;
				pend_d  = 1'b0;
				stamp_d = '0;
			end
			ble_aes_pkg::MODE_IFS: begin
				if (!item.timed_out && flow_q != FS_RSP) begin
					case (flow_q)
						FS_ADV:    flow_d = FS_LISTEN;
						FS_LISTEN: flow_d = FS_RSP;
						default:   flow_d = FS_DONE;
					endcase
				end else begin
					flow_d = adv_flow;
					chan_d = adv_chan;
				end
			end
			ble_aes_pkg::MODE_RX_PACKET: begin
				if (flow_q == FS_RSP) begin
					if (conn_ok) begin
						flow_d  = FS_DONE;
						pend_d  = 1'b1;
						stamp_d = item.timestamp;
					end else if (!scan_ok) begin
						flow_d = adv_flow;
						chan_d = adv_chan;
					end
				end
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		result.channel       = chan_d;
		result.radio_phy     = cfg.phy_mode;
		result.connect_found = pend_d;
		result.connect_time  = pend_d ? stamp_d : 32'd0;
		if (pend_d) begin
			result.radio_action = ble_aes_pkg::ACT_NONE;
		end else begin
			case (flow_d)
				FS_ADV:    result.radio_action = ble_aes_pkg::ACT_SEND_ADV;
				FS_LISTEN: result.radio_action = ble_aes_pkg::ACT_RX_REQ;
				FS_RSP:    result.radio_action = ble_aes_pkg::ACT_SCAN_RSP;
				default:   result.radio_action = ble_aes_pkg::ACT_NONE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flow_q  <= FS_DONE;
			chan_q  <= ble_aes_pkg::CHAN_FIRST;
			pend_q  <= 1'b0;
			stamp_q <= '0;
		end else if (step) begin
			flow_q  <= flow_d;
			chan_q  <= chan_d;
			pend_q  <= pend_d;
			stamp_q <= stamp_d;
		end
	end

endmodule

`default_nettype wire
